[hdl/mpeg2_video_header_rewriter_unit_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef MPEG2_VIDEO_HEADER_REWRITER_UNIT_MACROS_SVH
`define MPEG2_VIDEO_HEADER_REWRITER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MVHR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MVHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mvhr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mvhr_pkg;

  // Start code values that follow 00 00 01.
  localparam logic [7:0] CODE_PICTURE   = 8'h00;
  localparam logic [7:0] CODE_SEQUENCE  = 8'hB3;
  localparam logic [7:0] CODE_EXTENSION = 8'hB5;
  localparam logic [7:0] CODE_GOP       = 8'hB8;
  localparam logic [7:0] START_MARKER   = 8'h01;
  localparam logic [3:0] EXT_ID_DISPLAY = 4'h2;

  // Byte positions within a chunk; 0..2 are the start code prefix.
  localparam logic [3:0] POS_CODE   = 4'd3;
  localparam logic [3:0] POS_BYTE4  = 4'd4;
  localparam logic [3:0] POS_BYTE5  = 4'd5;
  localparam logic [3:0] POS_BYTE6  = 4'd6;
  localparam logic [3:0] POS_LAST   = 4'd7;
  localparam logic [3:0] NO_HEADER  = 4'd15;

  localparam logic [3:0] ASPECT_MIN = 4'd1;
  localparam logic [3:0] ASPECT_MAX = 4'd4;

  localparam int FRAMES_PER_SECOND  = 25;
  localparam int PICTURE_COUNT_BITS = 24;
  localparam int COUNT_OUT_BITS     = 24;
  localparam int FRAME_W            = 6;
  localparam logic [5:0] LAST_SEC_MIN = 6'd59;

  typedef struct packed {
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [FRAME_W-1:0] frame;
  } tc_t;

  typedef struct packed {
    logic [7:0]                byte_val;
    logic [COUNT_OUT_BITS-1:0] count;
  } result_t;

endpackage
`default_nettype wire

[hdl/mvhr_timecode.sv]
`timescale 1ns / 1ps
`default_nettype none
module mvhr_timecode #(
  parameter int FRAMES_PER_SECOND  = mvhr_pkg::FRAMES_PER_SECOND,
  parameter int PICTURE_COUNT_BITS = mvhr_pkg::PICTURE_COUNT_BITS
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           advance,
  output mvhr_pkg::tc_t                 tc,
  output logic [PICTURE_COUNT_BITS-1:0] count_next
);

  localparam logic [mvhr_pkg::FRAME_W-1:0] LAST_FRAME =
    mvhr_pkg::FRAME_W'(FRAMES_PER_SECOND - 1);

  logic [PICTURE_COUNT_BITS-1:0] pictures_seen;
  mvhr_pkg::tc_t                 tc_next;
  logic                          step;

  always_comb begin
    step       = advance && (pictures_seen != '1);
    tc_next    = tc;
    count_next = pictures_seen;
    if (step) begin
      count_next = pictures_seen + 1'b1;
      if (tc.frame == LAST_FRAME) begin
        tc_next.frame = '0;
        if (tc.second == mvhr_pkg::LAST_SEC_MIN) begin
          tc_next.second = '0;
          if (tc.minute == mvhr_pkg::LAST_SEC_MIN) begin
            tc_next.minute = '0;
            // hours wrap at 32 through the 5-bit field
            tc_next.hour   = tc.hour + 1'b1;
          end else begin
            tc_next.minute = tc.minute + 1'b1;
          end
        end else begin
          tc_next.second = tc.second + 1'b1;
        end
      end else begin
        tc_next.frame = tc.frame + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pictures_seen <= '0;
      tc            <= '0;
    end else begin
      pictures_seen <= count_next;
      tc            <= tc_next;
    end
  end

endmodule
`default_nettype wire

[hdl/mpeg2_video_header_rewriter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// MPEG-2 video elementary stream header rewriter. One stream byte enters per
// beat and leaves, registered in the output buffer, unchanged or patched:
// sequence header aspect code (when aspect_code is 1..4), sequence display
// extension video format bits (forced to the first ones seen) and GOP time
// code (rebuilt from the picture count). Each byte passes combinational
// logic into a two-entry output buffer, so a byte can be taken every cycle
// while it has room; the buffer lets two results wait before in_ready drops.
// picture_count reports picture start codes seen, including this byte.
// aspect_code is written with cfg_write and should change only while idle.
module mpeg2_video_header_rewriter_unit #(
  parameter int FRAMES_PER_SECOND  = mvhr_pkg::FRAMES_PER_SECOND,
  parameter int PICTURE_COUNT_BITS = mvhr_pkg::PICTURE_COUNT_BITS
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire  [3:0]  aspect_code,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_byte,
  output logic [23:0] picture_count
);

  logic [3:0] aspect_reg;
  logic [1:0] zero_run, zero_run_next;
  logic [7:0] chunk_code, chunk_code_next;
  logic [3:0] chunk_offset, chunk_offset_next;
  logic       format_latched, format_latched_next;
  logic [2:0] format_bits, format_bits_next;
  logic [7:0] patched;
  logic       picture_seen;
  logic       in_take, out_take;

  mvhr_pkg::tc_t                 tc;
  logic [PICTURE_COUNT_BITS-1:0] count_next;
  mvhr_pkg::result_t             result;

  mvhr_pkg::result_t buffer [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      aspect_reg <= '0;
    end else if (cfg_write) begin
      aspect_reg <= aspect_code;
    end
  end

  always_comb begin
    patched             = in_byte;
    chunk_offset_next   = chunk_offset;
    chunk_code_next     = chunk_code;
    format_latched_next = format_latched;
    format_bits_next    = format_bits;
    picture_seen        = 1'b0;
    if (zero_run == 2'd2 && in_byte == mvhr_pkg::START_MARKER) begin
      chunk_offset_next = mvhr_pkg::POS_CODE;
    end else if (chunk_offset >= mvhr_pkg::POS_CODE && chunk_offset <= mvhr_pkg::POS_LAST) begin
      chunk_offset_next = (chunk_offset == mvhr_pkg::POS_LAST) ? mvhr_pkg::NO_HEADER
                                                               : chunk_offset + 1'b1;
      if (chunk_offset == mvhr_pkg::POS_CODE) begin
        chunk_code_next = in_byte;
        picture_seen    = (in_byte == mvhr_pkg::CODE_PICTURE);
      end else begin
        unique case (chunk_code)
          mvhr_pkg::CODE_SEQUENCE: begin
            if (chunk_offset == mvhr_pkg::POS_LAST && aspect_reg >= mvhr_pkg::ASPECT_MIN &&
                aspect_reg <= mvhr_pkg::ASPECT_MAX) begin
              patched = {aspect_reg, in_byte[3:0]};
            end
          end
          mvhr_pkg::CODE_EXTENSION: begin
            if (chunk_offset == mvhr_pkg::POS_BYTE4 &&
                in_byte[7:4] == mvhr_pkg::EXT_ID_DISPLAY) begin
              if (!format_latched) begin
                format_latched_next = 1'b1;
                format_bits_next    = in_byte[3:1];
              end else begin
                patched = {in_byte[7:4], format_bits, in_byte[0]};
              end
            end
          end
          mvhr_pkg::CODE_GOP: begin
            unique case (chunk_offset)
              mvhr_pkg::POS_BYTE4: patched = {in_byte[7], tc.hour, tc.minute[5:4]};
              mvhr_pkg::POS_BYTE5: patched = {tc.minute[3:0], 1'b1, tc.second[5:3]};
              mvhr_pkg::POS_BYTE6: patched = {tc.second[2:0], tc.frame[5:1]};
              mvhr_pkg::POS_LAST:  patched = {tc.frame[0], in_byte[6:0]};
              default:             patched = in_byte;
            endcase
          end
          default: patched = in_byte;
        endcase
      end
    end
    // zero run follows the raw input, saturating at two
    if (in_byte == 8'h00) begin
      zero_run_next = (zero_run == 2'd2) ? 2'd2 : zero_run + 1'b1;
    end else begin
      zero_run_next = 2'd0;
    end
  end

  mvhr_timecode #(
    .FRAMES_PER_SECOND (FRAMES_PER_SECOND),
    .PICTURE_COUNT_BITS(PICTURE_COUNT_BITS)
  ) u_timecode (
    .clk       (clk),
    .rst       (rst),
    .advance   (in_take && picture_seen),
    .tc        (tc),
    .count_next(count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run       <= '0;
      chunk_code     <= '0;
      chunk_offset   <= mvhr_pkg::NO_HEADER;
      format_latched <= 1'b0;
      format_bits    <= '0;
    end else if (in_take) begin
      zero_run       <= zero_run_next;
      chunk_code     <= chunk_code_next;
      chunk_offset   <= chunk_offset_next;
      format_latched <= format_latched_next;
      format_bits    <= format_bits_next;
    end
  end

  assign result.byte_val = patched;
  assign result.count    = mvhr_pkg::COUNT_OUT_BITS'(count_next);

  // Two-entry output buffer: hold results while the sink stalls.
  always_ff @(posedge clk) begin
    if (in_take) begin
      buffer[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_take) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_take) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({in_take, out_take})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign in_ready      = (fill != 2'd2);
  assign out_valid     = (fill != 2'd0);
  assign out_byte      = buffer[rd_ptr].byte_val;
  assign picture_count = buffer[rd_ptr].count;

endmodule
`default_nettype wire

[hdl/mvhr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "mpeg2_video_header_rewriter_unit_macros.svh"
module mvhr_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [7:0]  out_byte,
  input wire [23:0] picture_count
);

  // stalled result beat stays up and unchanged
  `MVHR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out beat dropped")
  `MVHR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                    $stable(out_byte) && $stable(picture_count), "stalled out beat changed")
  // empty buffer must take input
  `MVHR_ASSERT_SAME(a_ready_empty, !out_valid, in_ready, "in_ready low with nothing pending")
  // out_valid is high in the cycle after every accepted byte
  `MVHR_ASSERT_NEXT(a_result_next, in_valid && in_ready, out_valid, "no result after in beat")

endmodule

bind mpeg2_video_header_rewriter_unit mvhr_checker u_mvhr_checker (.*);
`default_nettype wire
